// ----- design/htfd_pkg.sv -----
// Shared constants, types and the CRC-8 byte update for the sensor frame decoder.
package htfd_pkg;

    localparam logic [7:0] CRC_POLY        = 8'h31;
    localparam logic [7:0] CRC_INIT        = 8'hFF;
    localparam int         STATUS_BUSY_BIT = 7;

    localparam logic [2:0] IDX_FIRST_DATA  = 3'd1;
    localparam logic [2:0] IDX_CRC_BYTE    = 3'd6;
    localparam logic [2:0] IDX_IDLE        = 3'd7;

    localparam int PAYLOAD_BYTES = 6;
    localparam int RAW_BITS      = 20;
    localparam int HUM_BITS      = 7;
    localparam int TEMP_BITS     = 9;
    localparam int OUT_BITS      = 2 + 2 * RAW_BITS + HUM_BITS + TEMP_BITS + 8;
    localparam int OUT_BYTES_W   = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [6:0] HUM_SCALE    = 7'd100;
    localparam logic [7:0] TEMP_SCALE   = 8'd200;
    localparam logic [8:0] TEMP_OFFSET  = 9'd50;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_BUSY    = 2'd1,
        STATUS_CRC_ERR = 2'd2
    } frame_status_t;

    // MSB-first CRC-8 over one byte, eight shift steps unrolled
    function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ----- design/humidity_temp_frame_decoder_unit.sv -----
// Top level of the sensor read-frame decoder: byte tracking, CRC check, value conversion.
//
// Accepts one frame byte per clock cycle on the slave stream (tuser marks the status byte that
// opens a frame). The running CRC-8 and the payload bytes update at the accepting edge, and on
// the CRC byte the decoded result is loaded into the output register, so it appears on the
// master stream in the cycle after that byte is accepted. The output register decouples the two
// sides: the slave side only stalls while a finished result is held and the master side does
// not take it in that same cycle. Sustained rate is one byte per cycle; one result per
// seven-byte frame. Bytes without a frame start while idle are dropped, and a frame start
// always restarts the frame.
module humidity_temp_frame_decoder_unit
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [7:0]                           s_axis_tdata,   // [7:0] rx_byte
    input  logic                                 s_axis_tuser,   // [0] frame_start

    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [1:0] frame_status, [21:2] humidity_code, [41:22] temperature_code,
    // [48:42] humidity_percent, [57:49] temperature_celsius, [65:58] computed_crc, rest zero
    output logic [htfd_pkg::OUT_BYTES_W-1:0]     m_axis_tdata
);

    logic [2:0]  byte_index_reg, byte_index_next;
    logic [7:0]  crc_reg, crc_next;
    logic [7:0]  payload_reg [htfd_pkg::PAYLOAD_BYTES];

    logic                                out_valid_reg, out_valid_next;
    logic [htfd_pkg::OUT_BYTES_W-1:0]    out_data_reg, out_data_next;

    logic        s_accept;
    logic        data_byte;
    logic        crc_byte_in;
    logic [7:0]  crc_step;

    logic [htfd_pkg::RAW_BITS-1:0]       hum_raw, temp_raw;
    logic [htfd_pkg::RAW_BITS+6:0]       hum_prod;
    logic [htfd_pkg::RAW_BITS+7:0]       temp_prod;
    logic [htfd_pkg::HUM_BITS-1:0]       hum_pct;
    logic signed [htfd_pkg::TEMP_BITS-1:0] temp_c;
    htfd_pkg::frame_status_t             status;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign data_byte   = !s_axis_tuser && (byte_index_reg >= htfd_pkg::IDX_FIRST_DATA)
                         && (byte_index_reg < htfd_pkg::IDX_CRC_BYTE);
    assign crc_byte_in = !s_axis_tuser && (byte_index_reg == htfd_pkg::IDX_CRC_BYTE);

    // a frame start restarts the CRC from its initial value
    assign crc_step = htfd_pkg::crc_byte(s_axis_tuser ? htfd_pkg::CRC_INIT : crc_reg,
                                         s_axis_tdata);

    always_comb
    begin
        hum_raw  = {payload_reg[1], payload_reg[2], payload_reg[3][7:4]};
        temp_raw = {payload_reg[3][3:0], payload_reg[4], payload_reg[5]};
        hum_prod  = {7'd0, hum_raw} * {{(htfd_pkg::RAW_BITS){1'b0}}, htfd_pkg::HUM_SCALE};
        temp_prod = {8'd0, temp_raw} * {{(htfd_pkg::RAW_BITS){1'b0}}, htfd_pkg::TEMP_SCALE};
        hum_pct   = hum_prod[htfd_pkg::RAW_BITS +: htfd_pkg::HUM_BITS];
        temp_c    = $signed({1'b0, temp_prod[htfd_pkg::RAW_BITS +: 8]}
                            - htfd_pkg::TEMP_OFFSET);

        priority if (payload_reg[0][htfd_pkg::STATUS_BUSY_BIT])
        begin
            status = htfd_pkg::STATUS_BUSY;
        end
        else if (crc_reg != s_axis_tdata)
        begin
            status = htfd_pkg::STATUS_CRC_ERR;
        end
        else
        begin
            status = htfd_pkg::STATUS_OK;
        end
    end

    always_comb
    begin
        byte_index_next = byte_index_reg;
        crc_next        = crc_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (s_accept)
        begin
            if (s_axis_tuser)
            begin
                byte_index_next = htfd_pkg::IDX_FIRST_DATA;
                crc_next        = crc_step;
            end
            else if (data_byte)
            begin
                byte_index_next = byte_index_reg + 3'd1;
                crc_next        = crc_step;
            end
            else if (crc_byte_in)
            begin
                byte_index_next = htfd_pkg::IDX_IDLE;
                out_valid_next  = 1'b1;
                out_data_next   = {{(htfd_pkg::OUT_BYTES_W - htfd_pkg::OUT_BITS){1'b0}},
                                   crc_reg, temp_c, hum_pct, temp_raw, hum_raw, status};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg <= htfd_pkg::IDX_IDLE;
            crc_reg        <= htfd_pkg::CRC_INIT;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            byte_index_reg <= byte_index_next;
            crc_reg        <= crc_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload and result data carry no reset
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (s_accept && s_axis_tuser)
        begin
            payload_reg[0] <= s_axis_tdata;
        end
        else if (s_accept && data_byte)
        begin
            payload_reg[byte_index_reg] <= s_axis_tdata;
        end
    end

    // the CRC byte of a frame always produces a result next cycle
    a_crc_byte_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && crc_byte_in |=> m_axis_tvalid)
        else $error("CRC byte accepted without a result");

    // a frame start leaves the index at the first data byte and the CRC over the status byte
    a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && s_axis_tuser |=> byte_index_reg == htfd_pkg::IDX_FIRST_DATA
            && crc_reg == htfd_pkg::crc_byte(htfd_pkg::CRC_INIT, $past(s_axis_tdata)))
        else $error("frame start did not restart the frame");

    // the input side stalls only behind a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled with no result held");

    // index zero is never used
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        byte_index_reg != 3'd0)
        else $error("byte index left its range");

endmodule

// ----- dv/humidity_temp_frame_decoder_unit_test.sv -----
// Self-checking bench for the sensor read-frame decoder: random framed byte streams, scoreboard.
module humidity_temp_frame_decoder_unit_test;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 5;
    localparam int TARGET_ITEMS = 1700;
    localparam int LONG_HOLD    = 100;
    localparam int IDLE_LIMIT   = 2000;
    localparam int TAIL_CYCLES  = 10;

    // Result layout on the master stream, lowest bits last in the list
    typedef struct packed {
        logic [htfd_pkg::OUT_BYTES_W-htfd_pkg::OUT_BITS-1:0] pad;
        logic [7:0]                                          crc;
        logic signed [htfd_pkg::TEMP_BITS-1:0]               temp_c;
        logic [htfd_pkg::HUM_BITS-1:0]                       hum_pct;
        logic [htfd_pkg::RAW_BITS-1:0]                       temp_raw;
        logic [htfd_pkg::RAW_BITS-1:0]                       hum_raw;
        htfd_pkg::frame_status_t                             status;
    } frame_result_t;

    class frame_scoreboard;
        logic [2:0]    next_idx;
        logic [7:0]    crc_acc;
        logic [7:0]    frame_bytes[htfd_pkg::PAYLOAD_BYTES];
        frame_result_t decoded_q[$];
        int            errors;
        int            results_seen;
        int            ignored_bytes;
        int            status_count[3];

        function new();
            next_idx      = htfd_pkg::IDX_IDLE;
            crc_acc       = htfd_pkg::CRC_INIT;
            errors        = 0;
            results_seen  = 0;
            ignored_bytes = 0;
            foreach (status_count[i]) status_count[i] = 0;
        endfunction

        // bit-serial form: feed data bits MSB first into the shift register
        static function logic [7:0] crc8_update(logic [7:0] crc, logic [7:0] b);
            logic [7:0] r;
            logic       fb;
            r = crc;
            for (int i = 7; i >= 0; i--) begin
                fb = r[7] ^ b[i];
                r  = {r[6:0], 1'b0} ^ (fb ? htfd_pkg::CRC_POLY : 8'h00);
            end
            return r;
        endfunction

        // returns 0 when the byte is dropped by the block
        function bit note_request(logic [7:0] b, bit start);
            frame_result_t r;
            logic [htfd_pkg::RAW_BITS-1:0] hum;
            logic [htfd_pkg::RAW_BITS-1:0] tmp;
            if (start) begin
                frame_bytes[0] = b;
                crc_acc        = crc8_update(htfd_pkg::CRC_INIT, b);
                next_idx       = htfd_pkg::IDX_FIRST_DATA;
                return 1;
            end
            if (next_idx >= htfd_pkg::IDX_FIRST_DATA && next_idx < htfd_pkg::IDX_CRC_BYTE) begin
                frame_bytes[next_idx] = b;
                crc_acc               = crc8_update(crc_acc, b);
                next_idx              = next_idx + 3'd1;
                return 1;
            end
            if (next_idx != htfd_pkg::IDX_CRC_BYTE) begin
                ignored_bytes++;
                return 0;
            end
            next_idx = htfd_pkg::IDX_IDLE;
            hum = {frame_bytes[1], frame_bytes[2], frame_bytes[3][7:4]};
            tmp = {frame_bytes[3][3:0], frame_bytes[4], frame_bytes[5]};
            r.pad      = '0;
            r.crc      = crc_acc;
            r.hum_raw  = hum;
            r.temp_raw = tmp;
            r.hum_pct  = htfd_pkg::HUM_BITS'((longint'(hum) * 100) >> 20);
            r.temp_c   = htfd_pkg::TEMP_BITS'(((longint'(tmp) * 200) >> 20) - 50);
            if (frame_bytes[0][htfd_pkg::STATUS_BUSY_BIT])
                r.status = htfd_pkg::STATUS_BUSY;
            else if (crc_acc != b)
                r.status = htfd_pkg::STATUS_CRC_ERR;
            else
                r.status = htfd_pkg::STATUS_OK;
            decoded_q.push_back(r);
            return 1;
        endfunction

        function void mismatch(string field, longint exp_v, longint act_v);
            $display("%0t ERROR %s: expected %0d, actual %0d", $time, field, exp_v, act_v);
            errors++;
        endfunction

        function void check_result(frame_result_t got);
            frame_result_t e;
            if (decoded_q.size() == 0) begin
                $display("%0t ERROR unexpected result: expected none, actual %h", $time, got);
                errors++;
                return;
            end
            e = decoded_q.pop_front();
            results_seen++;
            status_count[e.status]++;
            if (got.status !== e.status)     mismatch("frame_status", e.status, got.status);
            if (got.hum_raw !== e.hum_raw)   mismatch("humidity_code", e.hum_raw, got.hum_raw);
            if (got.temp_raw !== e.temp_raw)
                mismatch("temperature_code", e.temp_raw, got.temp_raw);
            if (got.hum_pct !== e.hum_pct)   mismatch("humidity_percent", e.hum_pct, got.hum_pct);
            if (got.temp_c !== e.temp_c)
                mismatch("temperature_celsius", longint'(e.temp_c), longint'(got.temp_c));
            if (got.crc !== e.crc)           mismatch("computed_crc", e.crc, got.crc);
            if (got.pad !== e.pad)           mismatch("tdata padding", e.pad, got.pad);
        endfunction

        function int pending();
            return decoded_q.size();
        endfunction
    endclass

    logic                             clk;
    logic                             rst_n;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [7:0]                       s_axis_tdata;
    logic                             s_axis_tuser;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic [htfd_pkg::OUT_BYTES_W-1:0] m_axis_tdata;

    frame_scoreboard sb;
    int  items_done;
    int  burst_left;
    bit  steady;
    int  hold_request;
    int  hold_seen;
    int  idle_cycles;

    humidity_temp_frame_decoder_unit DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_PERIOD / 2) clk = ~clk;

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            sb.check_result(frame_result_t'(m_axis_tdata));
        end
    end

    // watchdog: cycles with no request moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t timeout: no request accepted for %0d cycles", $time, idle_cycles);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // receiver: stall pattern changes mode every so often, plus the long hold on request
    initial
    begin
        int mode;
        int mode_left;
        m_axis_tready <= 1'b0;
        hold_seen = 0;
        mode      = 0;
        mode_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_seen != hold_request)
            begin
                hold_seen = hold_request;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(50, 300);
            end
            mode_left--;
            case (mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 1) == 0);
                2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // offer one byte, wait for the handshake, and record it
    task automatic drive_byte(input logic [7:0] b, input bit start);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            burst_left = $urandom_range(1, 24);
            if (gap > 0 && !steady)
            begin
                s_axis_tvalid <= 1'b0;
                s_axis_tdata  <= 8'($urandom);
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= start;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (sb.note_request(b, start))
            items_done++;
    endtask

    // send the first len bytes of a frame; corrupt the CRC byte when bad_crc is set
    task automatic send_frame(input logic [7:0] status_byte, input logic [7:0] body[5],
                              input bit bad_crc, input int len);
        logic [7:0] f[7];
        logic [7:0] c;
        f[0] = status_byte;
        c    = frame_scoreboard::crc8_update(htfd_pkg::CRC_INIT, status_byte);
        for (int i = 0; i < 5; i++)
        begin
            f[i + 1] = body[i];
            c        = frame_scoreboard::crc8_update(c, body[i]);
        end
        f[6] = bad_crc ? (c ^ 8'($urandom_range(1, 255))) : c;
        for (int i = 0; i < len; i++)
            drive_byte(f[i], i == 0);
    endtask

    function automatic logic [7:0] pick_body_byte();
        int p;
        p = $urandom_range(0, 9);
        if (p == 0) return 8'h00;
        if (p == 1) return 8'hFF;
        return 8'($urandom);
    endfunction

    task automatic random_frame(input bit good_only, input int len);
        logic [7:0] body[5];
        logic [7:0] st;
        bit         bad;
        foreach (body[i]) body[i] = pick_body_byte();
        st = 8'($urandom);
        if (good_only || $urandom_range(0, 3) != 0)
            st[htfd_pkg::STATUS_BUSY_BIT] = 1'b0;
        bad = good_only ? 1'b0 : ($urandom_range(0, 4) == 0);
        send_frame(st, body, bad, len);
    endtask

    initial
    begin
        logic [7:0] ones[5];
        logic [7:0] zeros[5];
        bit         hold_done;
        bit         drain_done;
        int         pick;

        sb = new();
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        s_axis_tuser  <= 1'b0;
        items_done    = 0;
        burst_left    = 0;
        steady        = 1'b0;
        hold_request  = 0;
        idle_cycles   = 0;
        hold_done     = 1'b0;
        drain_done    = 1'b0;
        foreach (ones[i])  ones[i]  = 8'hFF;
        foreach (zeros[i]) zeros[i] = 8'h00;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: byte while idle, busy with top raw values and a bad CRC,
        // restart where the CRC byte was due, all-zero good frame, stray byte after end,
        // CRC mismatch without busy
        drive_byte(8'hA5, 1'b0);
        send_frame(8'h80, ones, 1'b1, 7);
        send_frame(8'h7F, ones, 1'b0, 6);
        send_frame(8'h00, zeros, 1'b0, 7);
        drive_byte(8'h5A, 1'b0);
        send_frame(8'h7F, ones, 1'b1, 7);

        while (items_done < TARGET_ITEMS)
        begin
            if (!hold_done && items_done >= 500)
            begin
                // receiver stops for a long stretch while frames keep coming back to back
                hold_done = 1'b1;
                hold_request <= hold_request + 1;
                steady = 1'b1;
                repeat (4) random_frame(1'b1, 7);
                steady = 1'b0;
            end
            else if (!drain_done && items_done >= 1100)
            begin
                drain_done = 1'b1;
                s_axis_tvalid <= 1'b0;
                while (sb.pending() != 0) @(posedge clk);
                repeat (3) @(posedge clk);
                burst_left = 0;
            end
            pick = $urandom_range(0, 99);
            if (pick < 78)
                random_frame(1'b0, 7);
            else if (pick < 90)
                random_frame(1'b0, $urandom_range(1, 6));
            else
            begin
                repeat ($urandom_range(1, 4))
                    drive_byte(8'($urandom), $urandom_range(0, 3) == 0);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Decoded %0d frames from %0d frame bytes; %0d idle bytes were dropped.",
                 sb.results_seen, items_done, sb.ignored_bytes);
        $display("Frame outcomes: ok %0d, sensor busy %0d, crc mismatch %0d.",
                 sb.status_count[htfd_pkg::STATUS_OK], sb.status_count[htfd_pkg::STATUS_BUSY],
                 sb.status_count[htfd_pkg::STATUS_CRC_ERR]);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
